// File: design/key_state_table_assert.svh
// ----------------------------------------------------------------------------
// key_state_table_assert
// assertion macros used by the key store module
// ----------------------------------------------------------------------------
`ifndef KEY_STATE_TABLE_ASSERT_SVH
`define KEY_STATE_TABLE_ASSERT_SVH

// checked property, ignored while reset is held
`define KST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property, also evaluated during reset
`define KST_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// types and constants shared by the key state table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

  // operation codes
  typedef enum logic [2:0] {
    MODE_EVENT     = 3'd0,
    MODE_QUERY     = 3'd1,
    MODE_CLEAR_ALL = 3'd2,
    MODE_CLEAR_ONE = 3'd3,
    MODE_FRAME     = 3'd4
  } mode_t;

  // event type code of a key event
  localparam logic [15:0] KEY_EVENT_TYPE = 16'd1;

  // event values that act
  localparam logic signed [31:0] VALUE_RELEASE = 32'sd0;
  localparam logic signed [31:0] VALUE_PRESS   = 32'sd1;

  // one input item
  typedef struct packed {
    mode_t              mode;
    logic [15:0]        event_type;
    logic [15:0]        key_code;
    logic signed [31:0] event_value;
  } item_t;

  // one result item
  typedef struct packed {
    logic key_held;
    logic key_seen;
    logic key_in_range;
  } result_t;

endpackage

`default_nettype wire

// File: design/kst_in_stage.sv
// ----------------------------------------------------------------------------
// kst_in_stage
// input register: holds one accepted item until the store takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kst_in_stage
  import kst_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // free when empty or when the held item moves on this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: design/kst_key_store.sv
// ----------------------------------------------------------------------------
// kst_key_store
// held and seen bit vectors, one operation applied per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "key_state_table_assert.svh"

module kst_key_store
  import kst_pkg::*;
#(
  parameter int KEY_COUNT = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire item_t item,
  output result_t    result
);

  localparam int          IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [16:0] KEY_LIMIT = 17'(KEY_COUNT);

  logic [KEY_COUNT-1:0] held_r;
  logic [KEY_COUNT-1:0] held_nxt;
  logic [KEY_COUNT-1:0] seen_r;
  logic [KEY_COUNT-1:0] seen_nxt;
  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  logic                 value_ok;
  logic                 ev_apply;

  // address decode
  assign in_range = {1'b0, item.key_code} < KEY_LIMIT;
  assign idx      = item.key_code[IDX_W-1:0];
  assign value_ok = (item.event_value == VALUE_RELEASE) ||
                    (item.event_value == VALUE_PRESS);
  assign ev_apply = (item.event_type == KEY_EVENT_TYPE) && value_ok && in_range;

  // next state of both vectors
  always_comb begin
    held_nxt = held_r;
    seen_nxt = seen_r;
    case (item.mode)
      MODE_EVENT: begin
        if (ev_apply) begin
          held_nxt[idx] = item.event_value[0];
          if (item.event_value[0]) begin
            seen_nxt[idx] = 1'b1;
          end
        end
      end
      MODE_CLEAR_ALL: begin
        held_nxt = '0;
      end
      MODE_CLEAR_ONE: begin
        if (in_range) begin
          held_nxt[idx] = 1'b0;
        end
      end
      MODE_FRAME: begin
        seen_nxt = '0;
      end
      default: begin
        held_nxt = held_r;
      end
    endcase
  end

  // state update on the item's step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      seen_r <= '0;
    end else if (fire) begin
      held_r <= held_nxt;
      seen_r <= seen_nxt;
    end
  end

  // addressed key after the operation
  assign result.key_held     = in_range && held_nxt[idx];
  assign result.key_seen     = in_range && seen_nxt[idx];
  assign result.key_in_range = in_range;

  // checks
  `KST_ASSERT_RST(a_reset_clears, !rst_n |=> (held_r == '0 && seen_r == '0), "reset left key bits set")
  `KST_ASSERT(a_idle_holds, !fire |=> ($stable(held_r) && $stable(seen_r)), "key bits changed with no item")
  `KST_ASSERT(a_frame_clears, (fire && item.mode == MODE_FRAME) |=> seen_r == '0, "frame start left seen bits")
  `KST_ASSERT(a_clear_all, (fire && item.mode == MODE_CLEAR_ALL) |=> held_r == '0, "clear all left held bits")

endmodule

`default_nettype wire

// File: design/kst_out_stage.sv
// ----------------------------------------------------------------------------
// kst_out_stage
// result register: holds one result until the consumer takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kst_out_stage
  import kst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t result,
  output logic         free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // room when empty or when the held result transfers this cycle
  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : ((valid_r && out_ready) ? 1'b0 : valid_r);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

// File: design/key_state_table.sv
// an item is held in the input register; its result is loaded into the result register when that has room
// throughput: one item per cycle while the output side takes results; the operation on the held and seen vectors
//   is one pass of logic between the input register and the result register
// reset: synchronous, active low; clears every held and seen bit at once and
//   empties both registers, so an item is taken in the first cycle after reset
// ----------------------------------------------------------------------------
// key_state_table
// per-key held and seen-this-frame tracker with event, query, clear and frame modes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_state_table
  import kst_pkg::*;
#(
  parameter int KEY_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [15:0] in_event_type,
  input  wire logic [15:0] in_key_code,
  input  wire logic signed [31:0] in_event_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_key_held,
  output logic             out_key_seen,
  output logic             out_key_in_range
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    advance;
  result_t result;
  result_t out_result;

  // pack the input fields
  assign in_item.mode        = mode_t'(in_mode);
  assign in_item.event_type  = in_event_type;
  assign in_item.key_code    = in_key_code;
  assign in_item.event_value = in_event_value;

  // an item moves on when the result register has room
  assign advance = item_valid && out_free;

  kst_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  kst_key_store #(
    .KEY_COUNT (KEY_COUNT)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item),
    .result (result)
  );

  kst_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  // unpack the result fields
  assign out_key_held     = out_result.key_held;
  assign out_key_seen     = out_result.key_seen;
  assign out_key_in_range = out_result.key_in_range;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives key events, queries and clears into the key state table and keeps its
// own copy of the held and seen vectors, so that every result transfer is
// checked field by field against the expected key report, under random
// idling on both sides and one long output stall
// ----------------------------------------------------------------------------

module testbench;
  import kst_pkg::*;

  localparam int KEY_TOTAL = 256;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTED = 40;

  // modes without an operation, they behave as a query
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  // key repeat value, ignored by the table
  localparam logic signed [31:0] VALUE_REPEAT = 32'sd2;

  // one operation as driven on the input ports
  typedef struct {
    logic [2:0]         mode;
    logic [15:0]        etype;
    logic [15:0]        code;
    logic signed [31:0] value;
  } key_op_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_mode = MODE_QUERY;
  logic [15:0] in_event_type = '0;
  logic [15:0] in_key_code = '0;
  logic signed [31:0] in_event_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_key_held;
  logic out_key_seen;
  logic out_key_in_range;

  // key state as it should stand in the table
  bit [KEY_TOTAL-1:0] held_keys;
  bit [KEY_TOTAL-1:0] seen_keys;
  result_t expected_reports[$];

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int stall_request = 0;
  int stall_left = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  key_state_table #(
    .KEY_COUNT(KEY_TOTAL)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_event_type    (in_event_type),
    .in_key_code      (in_key_code),
    .in_event_value   (in_event_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_held     (out_key_held),
    .out_key_seen     (out_key_seen),
    .out_key_in_range (out_key_in_range)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one operation to the key state and return the report it gives
  function automatic result_t apply_key_op(key_op_t op);
    result_t rep;
    logic hit;
    hit = op.code < KEY_TOTAL;
    case (op.mode)
      MODE_EVENT: begin
        if (hit && op.etype == KEY_EVENT_TYPE &&
            (op.value == VALUE_RELEASE || op.value == VALUE_PRESS)) begin
          held_keys[op.code] = (op.value == VALUE_PRESS);
          if (op.value == VALUE_PRESS) seen_keys[op.code] = 1'b1;
        end
      end
      MODE_CLEAR_ALL: held_keys = '0;
      MODE_CLEAR_ONE: begin
        if (hit) held_keys[op.code] = 1'b0;
      end
      MODE_FRAME: seen_keys = '0;
      default: ;
    endcase
    rep.key_held = hit ? held_keys[op.code] : 1'b0;
    rep.key_seen = hit ? seen_keys[op.code] : 1'b0;
    rep.key_in_range = hit;
    return rep;
  endfunction

  // key code, often one of a few keys so that state builds up
  function automatic logic [15:0] pick_key_code();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 16'($urandom_range(15));
    if (p < 75) return 16'($urandom_range(KEY_TOTAL - 1));
    if (p < 85) return 16'($urandom_range(65535, KEY_TOTAL));
    return 16'($urandom_range(65535));
  endfunction

  // random operation, mostly key events
  function automatic key_op_t pick_key_op();
    key_op_t op;
    int p;
    p = $urandom_range(99);
    if (p < 55) op.mode = MODE_EVENT;
    else if (p < 72) op.mode = MODE_QUERY;
    else if (p < 82) op.mode = MODE_CLEAR_ONE;
    else if (p < 85) op.mode = MODE_CLEAR_ALL;
    else if (p < 93) op.mode = MODE_FRAME;
    else op.mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    op.etype = ($urandom_range(99) < 85) ? KEY_EVENT_TYPE : 16'($urandom_range(65535));
    op.code = pick_key_code();
    p = $urandom_range(99);
    if (p < 40) op.value = VALUE_PRESS;
    else if (p < 70) op.value = VALUE_RELEASE;
    else if (p < 80) op.value = VALUE_REPEAT;
    else op.value = $urandom;
    return op;
  endfunction

  // offer one operation and record its report once it transfers
  task automatic send_op(input key_op_t op);
    while (send_idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= op.mode;
    in_event_type  <= op.etype;
    in_key_code    <= op.code;
    in_event_value <= op.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_reports.push_back(apply_key_op(op));
  endtask

  task automatic send_fields(input logic [2:0] mode, input logic [15:0] etype,
                             input logic [15:0] code, input logic signed [31:0] value);
    key_op_t op;
    op.mode = mode;
    op.etype = etype;
    op.code = code;
    op.value = value;
    send_op(op);
  endtask

  // compare one field of a report
  task automatic check_field(input string name, input logic exp_bit, input logic act_bit);
    if (exp_bit !== act_bit) begin
      error_count++;
      if (error_count <= MAX_REPORTED)
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_bit,
                 act_bit);
    end
  endtask

  // result side: check each transfer, then drive ready
  always @(posedge clk) begin
    result_t exp_rep;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTED)
          $display("%0t: result with nothing expected, actual %0b%0b%0b", $time,
                   out_key_held, out_key_seen, out_key_in_range);
      end else begin
        exp_rep = expected_reports.pop_front();
        check_field("key_held", exp_rep.key_held, out_key_held);
        check_field("key_seen", exp_rep.key_seen, out_key_seen);
        check_field("key_in_range", exp_rep.key_in_range, out_key_in_range);
      end
    end
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !recv_idle_on || $urandom_range(99) >= 36;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // extremes of every field, every mode and the ignored cases
  task automatic test_directed();
    logic [2:0] m;
    send_fields(MODE_QUERY, KEY_EVENT_TYPE, 16'd0, VALUE_RELEASE);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'd0, VALUE_PRESS);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'(KEY_TOTAL - 1), VALUE_PRESS);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'(KEY_TOTAL), VALUE_PRESS);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'hFFFF, VALUE_PRESS);
    send_fields(MODE_QUERY, KEY_EVENT_TYPE, 16'(KEY_TOTAL), VALUE_PRESS);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'd0, VALUE_RELEASE);
    // ignored values: repeat and the signed extremes
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'd5, VALUE_REPEAT);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'd5, 32'sh8000_0000);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'd5, 32'sh7FFF_FFFF);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'd5, -32'sd1);
    // other event types
    send_fields(MODE_EVENT, 16'd0, 16'd7, VALUE_PRESS);
    send_fields(MODE_EVENT, 16'hFFFF, 16'd7, VALUE_PRESS);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'd10, VALUE_PRESS);
    // single and full clears, then frame start
    send_fields(MODE_CLEAR_ONE, 16'hFFFF, 16'(KEY_TOTAL - 1), 32'sh7FFF_FFFF);
    send_fields(MODE_CLEAR_ONE, KEY_EVENT_TYPE, 16'hFFFF, VALUE_PRESS);
    send_fields(MODE_QUERY, 16'd0, 16'(KEY_TOTAL - 1), VALUE_RELEASE);
    send_fields(MODE_CLEAR_ALL, KEY_EVENT_TYPE, 16'd10, VALUE_RELEASE);
    send_fields(MODE_EVENT, KEY_EVENT_TYPE, 16'd10, VALUE_PRESS);
    for (m = MODE_SPARE_FIRST; m != 3'd0; m++)
      send_fields(m, KEY_EVENT_TYPE, 16'd10, VALUE_RELEASE);
    send_fields(MODE_FRAME, KEY_EVENT_TYPE, 16'd10, VALUE_RELEASE);
    send_fields(MODE_QUERY, KEY_EVENT_TYPE, 16'd0, VALUE_RELEASE);
  endtask

  // random traffic with idling on both sides
  task automatic test_random_traffic(input int count);
    repeat (count) send_op(pick_key_op());
  endtask

  // back-to-back transfers with no idling at all
  task automatic test_full_rate(input int count);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (count) send_op(pick_key_op());
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // long output stall while items keep coming, so the input backs up
  task automatic test_output_stall(input int count);
    send_idle_on = 1'b0;
    stall_request = 80;
    repeat (count) send_op(pick_key_op());
    send_idle_on = 1'b1;
  endtask

  // sequence of tests
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(700);
    test_output_stall(40);
    test_full_rate(300);
    test_random_traffic(540);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
